// File: rtl/core/kps_pkg.sv
// shared types and constants of the 4x4 keypad scanner
package kps_pkg;

	localparam int unsigned ROWS = 4;
	localparam int unsigned COLS = 4;
	localparam int unsigned KEYS = ROWS * COLS;

	localparam logic [3:0] ALL_ROWS = 4'b1111;
	localparam logic [1:0] LAST_ROW = 2'b11;

	localparam logic [7:0] SETTLE_TICKS_RST = 8'd8;
	localparam logic AUTO_SCAN_RST = 1'b1;

	typedef enum logic [0:0] {
		CFG_SETTLE_TICKS = 1'b0,
		CFG_AUTO_SCAN    = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic [3:0]  row_drive;
		logic        scan_done;
		logic [15:0] key_mask;
	} scan_res_t;

	typedef struct packed {
		logic [3:0] key_code;
		logic       key_found;
		logic       ghost_free;
	} mask_info_t;

endpackage

// File: rtl/core/kps_in_if.sv
// input item channel: tick with scan request and column sample
interface kps_in_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [3:0] col_levels;

	modport source (output valid, output req_type, output col_levels, input ready);
	modport sink (input valid, input req_type, input col_levels, output ready);
endinterface

// File: rtl/core/kps_out_if.sv
// result item channel: row drive and scan report
interface kps_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  row_drive;
	logic        scan_done;
	logic [15:0] key_mask;
	logic [3:0]  key_code;
	logic        key_found;
	logic        combination_valid;
	logic [3:0]  last_key;
	logic        last_key_valid;

	modport source (
		output valid, output row_drive, output scan_done, output key_mask,
		output key_code, output key_found, output combination_valid,
		output last_key, output last_key_valid, input ready
	);
	modport sink (
		input valid, input row_drive, input scan_done, input key_mask,
		input key_code, input key_found, input combination_valid,
		input last_key, input last_key_valid, output ready
	);
endinterface

// File: rtl/core/matrix_keypad_scanner.sv
// top level of the 4x4 keypad scanner
// Each input item is one timer tick carrying a software scan request flag and
// the four raw column levels; each item yields exactly one result item with the
// row drive for that tick and, on the tick the last row is sampled, the key
// mask, first key, found and ghost-free flags. One item is taken every clock
// cycle: the scan state updates in the cycle an item is accepted and the result
// is loaded into a single output register in that cycle, and the input only
// stalls while that register is full and not being taken. A scan lasts
// 4 * (settle_ticks + 1) items, with the wait capped at the settle counter's
// maximum. Configuration is written through cfg_we, cfg_index, cfg_wdata.
module matrix_keypad_scanner #(
	parameter int unsigned SETTLE_COUNT_BITS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_wdata,
	kps_in_if.sink     item_in,
	kps_out_if.source  item_out
);

	logic [7:0] settle_ticks_q;
	logic       auto_scan_q;
	logic       out_valid_q;
	logic       step;

	kps_pkg::scan_res_t  res;
	kps_pkg::mask_info_t info;
	logic [3:0]          last_key;
	logic                last_key_valid;

	assign item_in.ready = !out_valid_q || item_out.ready;
	assign step = item_in.valid && item_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_ticks_q <= kps_pkg::SETTLE_TICKS_RST;
			auto_scan_q <= kps_pkg::AUTO_SCAN_RST;
		end else if (cfg_we) begin
			unique case (kps_pkg::cfg_index_t'(cfg_index))
				kps_pkg::CFG_SETTLE_TICKS: settle_ticks_q <= cfg_wdata;
				kps_pkg::CFG_AUTO_SCAN:    auto_scan_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	kps_scan #(
		.SETTLE_COUNT_BITS(SETTLE_COUNT_BITS)
	) u_scan (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (step),
		.req_type         (item_in.req_type),
		.col_levels       (item_in.col_levels),
		.settle_ticks     (settle_ticks_q),
		.auto_scan_enable (auto_scan_q),
		.info             (info),
		.res              (res),
		.last_key         (last_key),
		.last_key_valid   (last_key_valid)
	);

	kps_decode u_decode (
		.key_mask (res.key_mask),
		.info     (info)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (item_in.ready) begin
			out_valid_q <= item_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			item_out.row_drive <= res.row_drive;
			item_out.scan_done <= res.scan_done;
			item_out.key_mask <= res.key_mask;
			item_out.key_code <= res.scan_done ? info.key_code : 4'd0;
			item_out.key_found <= res.scan_done && info.key_found;
			item_out.combination_valid <= res.scan_done && info.ghost_free;
			item_out.last_key <= last_key;
			item_out.last_key_valid <= last_key_valid;
		end
	end

	assign item_out.valid = out_valid_q;

endmodule

// File: rtl/core/kps_decode.sv
// first pressed key and ghost-free check of a completed key mask
module kps_decode (
	input  logic [15:0]         key_mask,
	output kps_pkg::mask_info_t info
);

	always_comb begin
		logic       row_seen;
		logic       col_seen;
		logic       ghost;
		logic [3:0] kb;
		logic [3:0] jb;
		info.key_code = 4'd0;
		info.key_found = |key_mask;
		ghost = 1'b0;
		// priority pick, lowest code wins
		for (int k = int'(kps_pkg::KEYS) - 1; k >= 0; k--) begin
			if (key_mask[k]) begin
				info.key_code = 4'(k);
			end
		end
		// a key is a ghost if earlier keys cover both its row and its column
		for (int k = 0; k < int'(kps_pkg::KEYS); k++) begin
			kb = 4'(k);
			row_seen = 1'b0;
			col_seen = 1'b0;
			for (int j = 0; j < int'(kps_pkg::KEYS); j++) begin
				jb = 4'(j);
				if (j < k && key_mask[j]) begin
					if (jb[3:2] == kb[3:2]) begin
						row_seen = 1'b1;
					end
					if (jb[1:0] == kb[1:0]) begin
						col_seen = 1'b1;
					end
				end
			end
			if (key_mask[k] && row_seen && col_seen) begin
				ghost = 1'b1;
			end
		end
		info.ghost_free = !ghost;
	end

endmodule

// File: rtl/core/kps_scan.sv
// scan sequencer: row stepping, settle counter, mask capture, held key
module kps_scan #(
	parameter int unsigned SETTLE_COUNT_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic                  req_type,
	input  logic [3:0]            col_levels,
	input  logic [7:0]            settle_ticks,
	input  logic                  auto_scan_enable,
	input  kps_pkg::mask_info_t   info,
	output kps_pkg::scan_res_t    res,
	output logic [3:0]            last_key,
	output logic                  last_key_valid
);

	localparam int unsigned CW = (SETTLE_COUNT_BITS > 8) ? SETTLE_COUNT_BITS : 8;
	localparam logic [CW-1:0] CNT_MAX = CW'((64'd1 << SETTLE_COUNT_BITS) - 64'd1);

	logic                         scanning_q;
	logic [1:0]                   row_q;
	logic [SETTLE_COUNT_BITS-1:0] settle_q;
	logic [15:0]                  mask_q;
	logic [3:0]                   prev_cols_q;
	logic [3:0]                   held_key_q;
	logic                         held_valid_q;

	logic [CW-1:0]  ticks_ext;
	logic [CW-1:0]  limit;
	logic           waiting;
	logic           start;
	logic [3:0]     pressed;
	logic [15:0]    mask_next;
	logic           hold_upd;

	assign ticks_ext = CW'(settle_ticks);
	assign limit = (ticks_ext > CNT_MAX) ? CNT_MAX : ticks_ext;
	assign waiting = CW'(settle_q) < limit;
	assign start = req_type || (auto_scan_enable && |(prev_cols_q & ~col_levels));
	assign pressed = ~col_levels;
	assign mask_next = mask_q | ({12'd0, pressed} << {row_q, 2'b00});

	always_comb begin
		res.row_drive = kps_pkg::ALL_ROWS;
		res.scan_done = 1'b0;
		res.key_mask = 16'd0;
		if (scanning_q) begin
			res.row_drive = 4'b0001 << row_q;
			if (!waiting && row_q == kps_pkg::LAST_ROW) begin
				res.scan_done = 1'b1;
				res.key_mask = mask_next;
			end
		end
	end

	assign hold_upd = res.scan_done && info.key_found;
	assign last_key = hold_upd ? info.key_code : held_key_q;
	assign last_key_valid = held_valid_q || hold_upd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scanning_q <= 1'b0;
			row_q <= 2'd0;
			settle_q <= '0;
			mask_q <= 16'd0;
			prev_cols_q <= 4'b1111;
			held_key_q <= 4'd0;
			held_valid_q <= 1'b0;
		end else if (step) begin
			held_key_q <= last_key;
			held_valid_q <= last_key_valid;
			if (!scanning_q) begin
				prev_cols_q <= col_levels;
				if (start) begin
					scanning_q <= 1'b1;
					row_q <= 2'd0;
					settle_q <= '0;
					mask_q <= 16'd0;
				end
			end else if (waiting) begin
				settle_q <= settle_q + 1'b1;
			end else begin
				mask_q <= mask_next;
				settle_q <= '0;
				row_q <= row_q + 2'd1;
				if (row_q == kps_pkg::LAST_ROW) begin
					scanning_q <= 1'b0;
				end
			end
		end
	end

endmodule

// File: tb/sv/testbench.sv
// self-checking testbench of the 4x4 keypad scanner: directed table, then random ticks
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import kps_pkg::*;

	localparam int CNT_BITS = 8;
	localparam int CNT_MAX = (1 << CNT_BITS) - 1;
	localparam int HOLD_CYCLES = 200;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASES = 7;
	localparam int PH_SETTLE [PHASES] = '{1, 0, 2, 255, 0, 3, 1};
	localparam int PH_AUTO [PHASES] = '{1, 0, 1, 1, 1, 0, 1};
	localparam int PH_ITEMS [PHASES] = '{250, 200, 250, 300, 100, 150, 100};

	typedef struct packed {
		logic [3:0]  row_drive;
		logic        scan_done;
		logic [15:0] key_mask;
		logic [3:0]  key_code;
		logic        key_found;
		logic        combination_valid;
		logic [3:0]  last_key;
		logic        last_key_valid;
	} tick_res_t;

	typedef enum logic {
		ROW_TICK,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		row_kind_t  kind;
		cfg_index_t reg_idx;
		logic [7:0] reg_val;
		logic       req;
		logic [3:0] cols;
		logic       typed;
		tick_res_t  want;
	} dir_row_t;

	localparam tick_res_t NO_RES = '0;
	localparam int DIR_ROWS = 29;

	dir_row_t dir_tab [DIR_ROWS] = '{
		'{ROW_TICK, CFG_SETTLE_TICKS, 8'd0, 1'b0, 4'hF, 1'b1,
			'{4'hF, 1'b0, 16'h0000, 4'h0, 1'b0, 1'b0, 4'h0, 1'b0}},
		'{ROW_CFG, CFG_SETTLE_TICKS, 8'd0, 1'b0, 4'hF, 1'b0, NO_RES},
		'{ROW_TICK, CFG_SETTLE_TICKS, 8'd0, 1'b1, 4'hF, 1'b1,
			'{4'hF, 1'b0, 16'h0000, 4'h0, 1'b0, 1'b0, 4'h0, 1'b0}},
		'{ROW_TICK, CFG_SETTLE_TICKS, 8'd0, 1'b0, 4'hF, 1'b1,
			'{4'h1, 1'b0, 16'h0000, 4'h0, 1'b0, 1'b0, 4'h0, 1'b0}},
		'{ROW_TICK, CFG_SETTLE_TICKS, 8'd0, 1'b0, 4'hF, 1'b1,
			'{4'h2, 1'b0, 16'h0000, 4'h0, 1'b0, 1'b0, 4'h0, 1'b0}},
		'{ROW_TICK, CFG_SETTLE_TICKS, 8'd0, 1'b0, 4'hF, 1'b1,
			'{4'h4, 1'b0, 16'h0000, 4'h0, 1'b0, 1'b0, 4'h0, 1'b0}},
		'{ROW_TICK, CFG_SETTLE_TICKS, 8'd0, 1'b0, 4'hF, 1'b1,
			'{4'h8, 1'b1, 16'h0000, 4'h0, 1'b0, 1'b1, 4'h0, 1'b0}},
		'{ROW_TICK, CFG_SETTLE_TICKS, 8'd0, 1'b0, 4'hE, 1'b1,
			'{4'hF, 1'b0, 16'h0000, 4'h0, 1'b0, 1'b0, 4'h0, 1'b0}},
		'{ROW_TICK, CFG_SETTLE_TICKS, 8'd0, 1'b0, 4'h0, 1'b1,
			'{4'h1, 1'b0, 16'h0000, 4'h0, 1'b0, 1'b0, 4'h0, 1'b0}},
		'{ROW_TICK, CFG_SETTLE_TICKS, 8'd0, 1'b0, 4'h0, 1'b1,
			'{4'h2, 1'b0, 16'h0000, 4'h0, 1'b0, 1'b0, 4'h0, 1'b0}},
		'{ROW_TICK, CFG_SETTLE_TICKS, 8'd0, 1'b0, 4'h0, 1'b1,
			'{4'h4, 1'b0, 16'h0000, 4'h0, 1'b0, 1'b0, 4'h0, 1'b0}},
		'{ROW_TICK, CFG_SETTLE_TICKS, 8'd0, 1'b0, 4'h0, 1'b1,
			'{4'h8, 1'b1, 16'hFFFF, 4'h0, 1'b1, 1'b0, 4'h0, 1'b1}},
		'{ROW_TICK, CFG_SETTLE_TICKS, 8'd0, 1'b1, 4'hF, 1'b1,
			'{4'hF, 1'b0, 16'h0000, 4'h0, 1'b0, 1'b0, 4'h0, 1'b1}},
		'{ROW_TICK, CFG_SETTLE_TICKS, 8'd0, 1'b0, 4'hF, 1'b1,
			'{4'h1, 1'b0, 16'h0000, 4'h0, 1'b0, 1'b0, 4'h0, 1'b1}},
		'{ROW_TICK, CFG_SETTLE_TICKS, 8'd0, 1'b0, 4'hF, 1'b1,
			'{4'h2, 1'b0, 16'h0000, 4'h0, 1'b0, 1'b0, 4'h0, 1'b1}},
		'{ROW_TICK, CFG_SETTLE_TICKS, 8'd0, 1'b0, 4'hF, 1'b1,
			'{4'h4, 1'b0, 16'h0000, 4'h0, 1'b0, 1'b0, 4'h0, 1'b1}},
		'{ROW_TICK, CFG_SETTLE_TICKS, 8'd0, 1'b0, 4'h7, 1'b1,
			'{4'h8, 1'b1, 16'h8000, 4'hF, 1'b1, 1'b1, 4'hF, 1'b1}},
		'{ROW_CFG, CFG_AUTO_SCAN, 8'd0, 1'b0, 4'hF, 1'b0, NO_RES},
		'{ROW_TICK, CFG_SETTLE_TICKS, 8'd0, 1'b0, 4'h0, 1'b1,
			'{4'hF, 1'b0, 16'h0000, 4'h0, 1'b0, 1'b0, 4'hF, 1'b1}},
		'{ROW_TICK, CFG_SETTLE_TICKS, 8'd0, 1'b1, 4'hF, 1'b1,
			'{4'hF, 1'b0, 16'h0000, 4'h0, 1'b0, 1'b0, 4'hF, 1'b1}},
		'{ROW_TICK, CFG_SETTLE_TICKS, 8'd0, 1'b1, 4'h5, 1'b0, NO_RES},
		'{ROW_TICK, CFG_SETTLE_TICKS, 8'd0, 1'b0, 4'hA, 1'b0, NO_RES},
		'{ROW_TICK, CFG_SETTLE_TICKS, 8'd0, 1'b1, 4'h6, 1'b0, NO_RES},
		'{ROW_TICK, CFG_SETTLE_TICKS, 8'd0, 1'b0, 4'hE, 1'b0, NO_RES},
		'{ROW_TICK, CFG_SETTLE_TICKS, 8'd0, 1'b1, 4'hF, 1'b0, NO_RES},
		'{ROW_TICK, CFG_SETTLE_TICKS, 8'd0, 1'b0, 4'hB, 1'b0, NO_RES},
		'{ROW_CFG, CFG_SETTLE_TICKS, 8'd2, 1'b0, 4'hF, 1'b0, NO_RES},
		'{ROW_TICK, CFG_SETTLE_TICKS, 8'd0, 1'b0, 4'hD, 1'b0, NO_RES},
		'{ROW_TICK, CFG_SETTLE_TICKS, 8'd0, 1'b1, 4'hF, 1'b0, NO_RES}
	};

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_index;
	logic [7:0] cfg_wdata;

	kps_in_if  in_ch ();
	kps_out_if out_ch ();

	matrix_keypad_scanner #(
		.SETTLE_COUNT_BITS(CNT_BITS)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.item_in   (in_ch),
		.item_out  (out_ch)
	);

	// scanner state as seen from outside
	logic                scan_busy;
	logic [1:0]          scan_row;
	logic [CNT_BITS-1:0] settle_cnt;
	logic [15:0]         key_acc;
	logic [3:0]          cols_seen;
	logic [3:0]          held_code;
	logic                held_ok;
	logic [7:0]          settle_cfg;
	logic                auto_cfg;

	tick_res_t   expected_ticks [$];
	int          mismatches = 0;
	int          results_seen = 0;
	bit          no_idle = 1'b0;
	bit          hold_off_req = 1'b0;
	logic [15:0] key_pattern = '0;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic tick_res_t predict_tick(input logic req, input logic [3:0] cols);
		tick_res_t   res;
		logic [3:0]  falling;
		logic [15:0] pressed;
		logic [3:0]  seen_r;
		logic [3:0]  seen_c;
		int          limit;
		res = '0;
		if (!scan_busy) begin
			falling = cols_seen & ~cols;
			res.row_drive = ALL_ROWS;
			cols_seen = cols;
			if (req || (auto_cfg && falling != 4'd0)) begin
				scan_busy = 1'b1;
				scan_row = 2'd0;
				settle_cnt = '0;
				key_acc = '0;
			end
		end else begin
			limit = (int'(settle_cfg) > CNT_MAX) ? CNT_MAX : int'(settle_cfg);
			res.row_drive = 4'b0001 << scan_row;
			if (int'(settle_cnt) < limit) begin
				settle_cnt = settle_cnt + 1'b1;
			end else begin
				pressed = {12'd0, ~cols};
				key_acc = key_acc | (pressed << (scan_row * 4));
				settle_cnt = '0;
				if (scan_row == LAST_ROW) begin
					res.scan_done = 1'b1;
					res.key_mask = key_acc;
					res.combination_valid = 1'b1;
					seen_r = '0;
					seen_c = '0;
					for (int k = 0; k < 16; k++) begin
						if (key_acc[k]) begin
							if (!res.key_found) begin
								res.key_code = 4'(k);
								res.key_found = 1'b1;
							end
							if (seen_r[k / 4] && seen_c[k % 4])
								res.combination_valid = 1'b0;
							seen_r[k / 4] = 1'b1;
							seen_c[k % 4] = 1'b1;
						end
					end
					if (res.key_found) begin
						held_code = res.key_code;
						held_ok = 1'b1;
					end
					scan_busy = 1'b0;
					scan_row = 2'd0;
				end else begin
					scan_row = scan_row + 2'd1;
				end
			end
		end
		res.last_key = held_code;
		res.last_key_valid = held_ok;
		return res;
	endfunction

	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// mostly keys held steady through a scan, some noise and stray requests
	function automatic void next_tick(output logic req, output logic [3:0] cols);
		int r;
		r = $urandom_range(0, 99);
		if (!scan_busy) begin
			if ($urandom_range(0, 7) == 0) begin
				key_pattern = 16'($urandom);
			end else begin
				key_pattern = '0;
				repeat ($urandom_range(0, 3)) key_pattern[$urandom_range(0, 15)] = 1'b1;
			end
			if (r < 15) begin
				req = 1'b1;
				cols = 4'hF;
			end else if (r < 35) begin
				req = 1'b0;
				cols = ~key_pattern[4 * $urandom_range(0, 3) +: 4];
			end else if (r < 42) begin
				req = 1'($urandom_range(0, 1));
				cols = 4'($urandom_range(0, 15));
			end else begin
				req = 1'b0;
				cols = 4'hF;
			end
		end else begin
			req = ($urandom_range(0, 7) == 0);
			if (r < 8)
				cols = 4'($urandom_range(0, 15));
			else
				cols = ~key_pattern[scan_row * 4 +: 4];
		end
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at result %0d: %s", results_seen, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	task automatic check_tick(input tick_res_t got);
		tick_res_t want;
		results_seen++;
		if (expected_ticks.size() == 0) begin
			report_mismatch("result with no item outstanding");
		end else begin
			want = expected_ticks.pop_front();
			check_field("row_drive", got.row_drive, want.row_drive);
			check_field("scan_done", got.scan_done, want.scan_done);
			check_field("key_mask", got.key_mask, want.key_mask);
			check_field("key_code", got.key_code, want.key_code);
			check_field("key_found", got.key_found, want.key_found);
			check_field("combination_valid", got.combination_valid,
				want.combination_valid);
			check_field("last_key", got.last_key, want.last_key);
			check_field("last_key_valid", got.last_key_valid, want.last_key_valid);
		end
	endtask

	// called at a falling edge, returns at a falling edge
	task automatic send_tick(input logic req, input logic [3:0] cols, input logic typed,
			input tick_res_t typed_res);
		int        gap;
		tick_res_t pred;
		gap = idle_gap();
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.req_type <= req;
		in_ch.col_levels <= cols;
		do @(posedge clk); while (!in_ch.ready);
		pred = predict_tick(req, cols);
		expected_ticks.push_back(typed ? typed_res : pred);
		@(negedge clk);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (expected_ticks.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [7:0] val);
		drain();
		repeat (2) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			CFG_SETTLE_TICKS: settle_cfg = val;
			CFG_AUTO_SCAN: auto_cfg = val[0];
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		logic       req;
		logic [3:0] cols;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_SETTLE_TICKS;
		cfg_wdata <= '0;
		in_ch.valid <= 1'b0;
		in_ch.req_type <= 1'b0;
		in_ch.col_levels <= 4'hF;
		settle_cfg = SETTLE_TICKS_RST;
		auto_cfg = AUTO_SCAN_RST;
		scan_busy = 1'b0;
		scan_row = '0;
		settle_cnt = '0;
		key_acc = '0;
		cols_seen = 4'hF;
		held_code = '0;
		held_ok = 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		foreach (dir_tab[i]) begin
			if (dir_tab[i].kind == ROW_CFG)
				write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
			else
				send_tick(dir_tab[i].req, dir_tab[i].cols, dir_tab[i].typed, dir_tab[i].want);
		end
		for (int p = 0; p < PHASES; p++) begin
			write_reg(CFG_SETTLE_TICKS, 8'(PH_SETTLE[p]));
			write_reg(CFG_AUTO_SCAN, 8'(PH_AUTO[p]));
			no_idle = (p == 2);
			for (int n = 0; n < PH_ITEMS[p]; n++) begin
				if (p == 2 && n == 40)
					hold_off_req = 1'b1;
				if (p == 1 && n == 100)
					drain();
				next_tick(req, cols);
				send_tick(req, cols, 1'b0, NO_RES);
			end
		end
		no_idle = 1'b0;
		drain();
		repeat (4) @(negedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin : result_sink
		tick_res_t got;
		bit        taken;
		int        stall;
		int        hold_left;
		stall = 0;
		hold_left = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			taken = out_ch.valid && out_ch.ready;
			got.row_drive = out_ch.row_drive;
			got.scan_done = out_ch.scan_done;
			got.key_mask = out_ch.key_mask;
			got.key_code = out_ch.key_code;
			got.key_found = out_ch.key_found;
			got.combination_valid = out_ch.combination_valid;
			got.last_key = out_ch.last_key;
			got.last_key_valid = out_ch.last_key_valid;
			@(negedge clk);
			if (taken)
				check_tick(got);
			if (hold_off_req) begin
				hold_left = HOLD_CYCLES;
				hold_off_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				out_ch.ready <= 1'b0;
			end else begin
				stall = idle_gap();
				if (stall == 0) begin
					out_ch.ready <= 1'b1;
				end else begin
					stall--;
					out_ch.ready <= 1'b0;
				end
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("no item moved for %0d cycles", quiet);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

endmodule

// File: files.f
rtl/core/kps_pkg.sv
rtl/core/kps_in_if.sv
rtl/core/kps_out_if.sv
rtl/core/kps_decode.sv
rtl/core/kps_scan.sv
rtl/core/matrix_keypad_scanner.sv
tb/sv/testbench.sv
